// File: design/source_token_scanner_core_defines.svh
// Assertion macros shared by the scanner checker.
`ifndef SOURCE_TOKEN_SCANNER_CORE_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_CORE_DEFINES_SVH

// Check a property outside reset.
`define STSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define STSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/stsc_pkg.sv
// Shared types, codes and keyword lookup for the source token scanner.
package stsc_pkg;

    localparam int KEYWORD_MAX = 8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    typedef enum logic [5:0] {
        K_LET, K_IF, K_ELSE, K_PRINT, K_WHILE, K_FOR, K_FUNCTION, K_RETURN,
        K_TRUE, K_FALSE, K_INT, K_FLOAT, K_BOOL, K_STRING_TYPE, K_VOID,
        K_IDENT, K_NUMBER, K_STRING, K_PLUS, K_MINUS, K_MULTIPLY, K_DIVIDE,
        K_ASSIGN, K_GT, K_LT, K_GTE, K_LTE, K_EQ, K_NE, K_AND, K_OR,
        K_NOT, K_LBRACE, K_RBRACE, K_LPAREN, K_RPAREN, K_SEMICOLON, K_COMMA,
        K_COLON, K_AT, K_NEWLINE, K_EOF, K_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE, E_UNTERM, E_AMP, E_BAR, E_UNEXP
    } t_err;

    typedef struct packed {
        t_kind       kind;
        t_err        err_code;
        logic [23:0] tok_start;
        logic [23:0] tok_len;
        logic [23:0] line_no;
        logic        last;
    } t_tok;

    typedef struct packed {
        logic [1:0]     cnt;
        t_tok [2:0]     toks;
    } t_push;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_dec_char(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Single-byte operators; K_ERROR when the byte is none of them.
    function automatic t_kind single_kind(logic [7:0] c);
        t_kind k;
        case (c)
            CH_LPAR:  k = K_LPAREN;
            CH_RPAR:  k = K_RPAREN;
            CH_LBRC:  k = K_LBRACE;
            CH_RBRC:  k = K_RBRACE;
            CH_SEMI:  k = K_SEMICOLON;
            CH_COMMA: k = K_COMMA;
            CH_COLON: k = K_COLON;
            CH_AT:    k = K_AT;
            CH_PLUS:  k = K_PLUS;
            CH_MINUS: k = K_MINUS;
            CH_STAR:  k = K_MULTIPLY;
            default:  k = K_ERROR;
        endcase
        return k;
    endfunction

    // Match the newest len bytes of the window against the keyword list.
    function automatic t_kind classify(logic [63:0] win, logic [3:0] len);
        t_kind k;
        k = K_IDENT;
        if (len <= 4'(KEYWORD_MAX)) begin
            case (len)
                4'd2: begin
                    if (win[15:0] == 16'h6966) k = K_IF;
                    else if (win[15:0] == 16'h666E) k = K_FUNCTION;
                end
                4'd3: begin
                    if (win[23:0] == 24'h6C6574) k = K_LET;
                    else if (win[23:0] == 24'h696E74) k = K_INT;
                    else if (win[23:0] == 24'h666F72) k = K_FOR;
                end
                4'd4: begin
                    if (win[31:0] == 32'h656C7365) k = K_ELSE;
                    else if (win[31:0] == 32'h74727565) k = K_TRUE;
                    else if (win[31:0] == 32'h626F6F6C) k = K_BOOL;
                    else if (win[31:0] == 32'h766F6964) k = K_VOID;
                end
                4'd5: begin
                    if (win[39:0] == 40'h7072696E74) k = K_PRINT;
                    else if (win[39:0] == 40'h7768696C65) k = K_WHILE;
                    else if (win[39:0] == 40'h66616C7365) k = K_FALSE;
                    else if (win[39:0] == 40'h666C6F6174) k = K_FLOAT;
                end
                4'd6: begin
                    if (win[47:0] == 48'h72657475726E) k = K_RETURN;
                    else if (win[47:0] == 48'h737472696E67) k = K_STRING_TYPE;
                end
                4'd8: begin
                    if (win == 64'h66756E6374696F6E) k = K_FUNCTION;
                end
                default: k = K_IDENT;
            endcase
        end
        return k;
    endfunction

endpackage

// File: design/stsc_src_if.sv
// Source byte channel.
interface stsc_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

// File: design/stsc_tok_if.sv
// Token channel.
interface stsc_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  kind;
    logic [2:0]  err_code;
    logic [23:0] tok_start;
    logic [23:0] tok_len;
    logic [23:0] line_no;
    logic        last;

    modport source (output valid, output kind, output err_code, output tok_start,
                    output tok_len, output line_no, output last, input ready);
    modport sink (input valid, input kind, input err_code, input tok_start,
                  input tok_len, input line_no, input last, output ready);
endinterface

// File: design/stsc_scan.sv
// Scan state and per-byte token decode.
module stsc_scan
    import stsc_pkg::*;
#(
    parameter int POS_WIDTH = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_ch,
    output t_push      o_push
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_SLASH, M_CMNT, M_OP
    } t_mode;

    localparam logic [POS_WIDTH-1:0] POS_MAX  = '1;
    localparam logic [23:0]          LINE_MAX = '1;

    t_mode                r_mode, n_mode;
    logic [POS_WIDTH-1:0] r_tb, n_tb;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [23:0]          r_line, n_line;
    logic [63:0]          r_win, n_win;
    logic [3:0]           r_ilen, n_ilen;
    logic [7:0]           r_pend, n_pend;

    function automatic logic [23:0] sat24(logic [32:0] v);
        return (v > 33'hFFFFFF) ? 24'hFFFFFF : v[23:0];
    endfunction

    function automatic t_tok mk(t_kind k, t_err e, logic [32:0] s, logic [32:0] l,
                                logic [23:0] ln);
        t_tok t;
        t.kind      = k;
        t.err_code  = e;
        t.tok_start = sat24(s);
        t.tok_len   = sat24(l);
        t.line_no   = ln;
        t.last      = 1'b0;
        return t;
    endfunction

    logic [32:0] pos33, tb33, span;
    assign pos33 = 33'(r_pos);
    assign tb33  = 33'(r_tb);
    assign span  = pos33 - tb33;

    always_comb begin
        t_push p;
        logic  reproc;
        logic  ended;
        t_kind k1;
        t_kind k2;
        t_kind sk;
        p      = '0;
        reproc = 1'b0;
        ended  = 1'b0;
        k1     = K_ERROR;
        k2     = K_ERROR;
        sk     = single_kind(i_ch);
        n_mode = r_mode;
        n_tb   = r_tb;
        n_pos  = r_pos;
        n_line = r_line;
        n_win  = r_win;
        n_ilen = r_ilen;
        n_pend = r_pend;

        // Flush the open token if this byte ends it.
        unique case (r_mode)
            M_IDENT: begin
                if (is_letter(i_ch) || is_dec_char(i_ch)) begin
                    n_win = {r_win[55:0], i_ch};
                    if (r_ilen != 4'hF) n_ilen = r_ilen + 4'd1;
                end else begin
                    p.toks[p.cnt] = mk(classify(r_win, r_ilen), E_NONE, tb33, span, r_line);
                    p.cnt = p.cnt + 2'd1;
                    reproc = 1'b1;
                end
            end
            M_INT, M_FRAC: begin
                if (r_mode == M_INT && i_ch == CH_DOT) begin
                    n_mode = M_DOT;
                end else if (!is_dec_char(i_ch)) begin
                    p.toks[p.cnt] = mk(K_NUMBER, E_NONE, tb33, span, r_line);
                    p.cnt = p.cnt + 2'd1;
                    reproc = 1'b1;
                end
            end
            M_DOT: begin
                if (is_dec_char(i_ch)) begin
                    n_mode = M_FRAC;
                end else begin
                    p.toks[p.cnt] = mk(K_NUMBER, E_NONE, tb33, span - 33'd1, r_line);
                    p.cnt = p.cnt + 2'd1;
                    p.toks[p.cnt] = mk(K_ERROR, E_UNEXP, pos33 - 33'd1, 33'd1, r_line);
                    p.cnt = p.cnt + 2'd1;
                    reproc = 1'b1;
                end
            end
            M_STR: begin
                if (i_ch == CH_QUOTE) begin
                    p.toks[p.cnt] = mk(K_STRING, E_NONE, tb33, span + 33'd1, r_line);
                    p.cnt = p.cnt + 2'd1;
                    n_mode = M_IDLE;
                end else if (i_ch == CH_NUL) begin
                    p.toks[p.cnt] = mk(K_ERROR, E_UNTERM, tb33, span, r_line);
                    p.cnt = p.cnt + 2'd1;
                    reproc = 1'b1;
                end else if (i_ch == CH_LF) begin
                    if (r_line != LINE_MAX) n_line = r_line + 24'd1;
                end
            end
            M_SLASH: begin
                if (i_ch == CH_SLASH) begin
                    n_mode = M_CMNT;
                end else begin
                    p.toks[p.cnt] = mk(K_DIVIDE, E_NONE, tb33, 33'd1, r_line);
                    p.cnt = p.cnt + 2'd1;
                    reproc = 1'b1;
                end
            end
            M_CMNT: begin
                if (i_ch == CH_LF || i_ch == CH_NUL) reproc = 1'b1;
            end
            M_OP: begin
                if (r_pend == CH_AMP || r_pend == CH_BAR) begin
                    if (i_ch == r_pend) begin
                        p.toks[p.cnt] = mk((r_pend == CH_AMP) ? K_AND : K_OR, E_NONE,
                                           tb33, 33'd2, r_line);
                        p.cnt = p.cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        p.toks[p.cnt] = mk(K_ERROR, (r_pend == CH_AMP) ? E_AMP : E_BAR,
                                           tb33, 33'd1, r_line);
                        p.cnt = p.cnt + 2'd1;
                        reproc = 1'b1;
                    end
                end else begin
                    case (r_pend)
                        CH_BANG: begin k1 = K_NOT;    k2 = K_NE;  end
                        CH_EQ:   begin k1 = K_ASSIGN; k2 = K_EQ;  end
                        CH_GT:   begin k1 = K_GT;     k2 = K_GTE; end
                        CH_LT:   begin k1 = K_LT;     k2 = K_LTE; end
                        default: begin k1 = K_ERROR;  k2 = K_ERROR; end
                    endcase
                    if (k1 == K_ERROR) begin
                        p.toks[p.cnt] = mk(K_ERROR, E_UNEXP, tb33, 33'd1, r_line);
                        p.cnt = p.cnt + 2'd1;
                        reproc = 1'b1;
                    end else if (i_ch == CH_EQ) begin
                        p.toks[p.cnt] = mk(k2, E_NONE, tb33, 33'd2, r_line);
                        p.cnt = p.cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        p.toks[p.cnt] = mk(k1, E_NONE, tb33, 33'd1, r_line);
                        p.cnt = p.cnt + 2'd1;
                        reproc = 1'b1;
                    end
                end
            end
            default: reproc = 1'b1;
        endcase

        // Handle the byte itself between tokens.
        if (reproc) begin
            n_mode = M_IDLE;
            if (i_ch == CH_NUL) begin
                p.toks[p.cnt] = mk(K_EOF, E_NONE, pos33, 33'd0, r_line);
                p.cnt = p.cnt + 2'd1;
                ended = 1'b1;
            end else if (i_ch == CH_LF) begin
                if (r_line != LINE_MAX) n_line = r_line + 24'd1;
            end else if (i_ch != CH_SPACE && i_ch != CH_CR && i_ch != CH_TAB) begin
                n_tb = r_pos;
                if (i_ch == CH_SLASH) begin
                    n_mode = M_SLASH;
                end else if (is_letter(i_ch)) begin
                    n_mode = M_IDENT;
                    n_win  = {56'd0, i_ch};
                    n_ilen = 4'd1;
                end else if (is_dec_char(i_ch)) begin
                    n_mode = M_INT;
                end else if (i_ch == CH_QUOTE) begin
                    n_mode = M_STR;
                end else if (i_ch == CH_BANG || i_ch == CH_EQ || i_ch == CH_LT ||
                             i_ch == CH_GT || i_ch == CH_AMP || i_ch == CH_BAR) begin
                    n_mode = M_OP;
                    n_pend = i_ch;
                end else if (sk != K_ERROR) begin
                    p.toks[p.cnt] = mk(sk, E_NONE, pos33, 33'd1, r_line);
                    p.cnt = p.cnt + 2'd1;
                end else begin
                    p.toks[p.cnt] = mk(K_ERROR, E_UNEXP, pos33, 33'd1, r_line);
                    p.cnt = p.cnt + 2'd1;
                end
            end
        end

        // End of source: drop back to the reset state.
        if (ended) begin
            n_mode = M_IDLE;
            n_tb   = '0;
            n_pos  = '0;
            n_line = 24'd1;
            n_win  = '0;
            n_ilen = '0;
            n_pend = '0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + 1'b1;
        end

        if (p.cnt != 2'd0) p.toks[p.cnt - 2'd1].last = 1'b1;
        o_push = p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_tb   <= '0;
            r_pos  <= '0;
            r_line <= 24'd1;
            r_win  <= '0;
            r_ilen <= '0;
            r_pend <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_tb   <= n_tb;
            r_pos  <= n_pos;
            r_line <= n_line;
            r_win  <= n_win;
            r_ilen <= n_ilen;
            r_pend <= n_pend;
        end
    end

endmodule

// File: design/stsc_outq.sv
// Four-entry token queue: takes up to three tokens a cycle, one out when ready.
module stsc_outq
    import stsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_push i_push,
    output logic o_room,
    stsc_tok_if.source o_tok
);

    t_tok       r_q [4];
    logic [1:0] r_rd;
    logic [1:0] r_wr;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic [1:0] push_n;
    logic       pop;

    assign push_n = i_fire ? i_push.cnt : 2'd0;
    assign pop    = o_tok.valid && o_tok.ready;
    assign n_cnt  = r_cnt + 3'(push_n) - 3'(pop);
    // At most one entry held leaves room for a three-token flush.
    assign o_room = r_cnt <= 3'd1;

    assign o_tok.valid     = r_cnt != 3'd0;
    assign o_tok.kind      = r_q[r_rd].kind;
    assign o_tok.err_code  = r_q[r_rd].err_code;
    assign o_tok.tok_start = r_q[r_rd].tok_start;
    assign o_tok.tok_len   = r_q[r_rd].tok_len;
    assign o_tok.line_no   = r_q[r_rd].line_no;
    assign o_tok.last      = r_q[r_rd].last;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < push_n) r_q[2'(r_wr + 2'(i))] <= i_push.toks[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + push_n;
            r_rd  <= r_rd + 2'(pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: design/source_token_scanner_core.sv
// Tokens that a byte sends are written into the token queue when the byte is accepted;
// the output is driven from the queue registers. Throughput: one byte per cycle while the
// token queue holds at most one entry; otherwise the input is held until it drains back.
// It drains one token per cycle when the receiver is ready; its depth of four sets the stall.
// Reset (synchronous, active low) clears scan state to offset 0, line 1, and empties the queue.
module source_token_scanner_core
    import stsc_pkg::*;
#(
    parameter int POS_WIDTH = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    stsc_src_if.sink   i_src,
    stsc_tok_if.source o_tok
);

    t_push push;
    logic  room;
    logic  fire;

    assign i_src.ready = room;
    assign fire        = i_src.valid && room;

    stsc_scan #(
        .POS_WIDTH(POS_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_ch    (i_src.ch),
        .o_push  (push)
    );

    stsc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_push  (push),
        .o_room  (room),
        .o_tok   (o_tok)
    );

endmodule

// File: design/stsc_chk.sv
// Port-level checks for the scanner, bound to the top level.
`include "source_token_scanner_core_defines.svh"

module stsc_chk
    import stsc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  i_kind,
    input logic [2:0]  i_err_code,
    input logic [23:0] i_tok_len,
    input logic [23:0] i_line_no,
    input logic        i_last
);

    `STSC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !i_out_valid, "token after reset")
    `STSC_ASSERT(a_hold, i_out_valid && !i_out_ready |=> i_out_valid, "token request dropped")
    `STSC_ASSERT(a_eof_shape, i_out_valid && i_kind == 6'(K_EOF) |-> i_last && i_tok_len == 24'd0, "bad end token")
    `STSC_ASSERT(a_err_only, i_out_valid && i_err_code != 3'(E_NONE) |-> i_kind == 6'(K_ERROR), "error code on non-error")
    `STSC_ASSERT(a_line_nonzero, i_out_valid |-> i_line_no != 24'd0, "line zero")

endmodule

bind source_token_scanner_core stsc_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_tok.valid),
    .i_out_ready (o_tok.ready),
    .i_kind      (o_tok.kind),
    .i_err_code  (o_tok.err_code),
    .i_tok_len   (o_tok.tok_len),
    .i_line_no   (o_tok.line_no),
    .i_last      (o_tok.last)
);

// File: tb/sv/tb_source_token_scanner_core.sv
// Testbench for the source token scanner: byte stream in, token stream checked against a predictor.
module tb_source_token_scanner_core;
    import stsc_pkg::*;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam logic [23:0] SAT24 = 24'hFFFFFF;

    typedef enum logic [3:0] {
        SC_IDLE, SC_WORD, SC_INT, SC_DOT, SC_FRAC, SC_STR, SC_SLASH, SC_CMNT, SC_OP
    } t_scan;

    logic i_clk;
    logic i_rst_n;

    stsc_src_if src ();
    stsc_tok_if tok ();

    source_token_scanner_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src.sink),
        .o_tok   (tok.source)
    );

    // Predictor state
    t_scan       sc_mode;
    logic [23:0] sc_begin;
    logic [23:0] sc_pos;
    logic [23:0] sc_line;
    logic [63:0] sc_window;
    logic [3:0]  sc_wlen;
    logic [7:0]  sc_pend;

    logic [7:0] byte_queue[$];
    t_tok       token_queue[$];
    t_tok       step_toks[$];

    bit     failed;
    bit     src_taken;
    bit     stim_done;
    int     accepted_bytes;
    int     cycle_cnt;
    int     src_gap;
    int     tok_gap;
    int     hold_cnt;
    bit     hold_used;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit letter_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic t_kind word_kind(logic [63:0] win, logic [3:0] len);
        string w;
        w = "";
        if (len < 2 || len > 8) return K_IDENT;
        for (int i = len - 1; i >= 0; i--) w = {w, string'(win[8*i +: 8])};
        case (w)
            "let": return K_LET;
            "if": return K_IF;
            "int": return K_INT;
            "else": return K_ELSE;
            "print": return K_PRINT;
            "while": return K_WHILE;
            "fn": return K_FUNCTION;
            "function": return K_FUNCTION;
            "for": return K_FOR;
            "false": return K_FALSE;
            "float": return K_FLOAT;
            "return": return K_RETURN;
            "true": return K_TRUE;
            "bool": return K_BOOL;
            "string": return K_STRING_TYPE;
            "void": return K_VOID;
            default: return K_IDENT;
        endcase
    endfunction

    function automatic t_kind punct_kind(logic [7:0] c);
        case (c)
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            ";": return K_SEMICOLON;
            ",": return K_COMMA;
            ":": return K_COLON;
            "@": return K_AT;
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_MULTIPLY;
            default: return K_ERROR;
        endcase
    endfunction

    task automatic emit_token(t_kind k, t_err e, logic [23:0] start, logic [24:0] len);
        t_tok t;
        if (step_toks.size() >= 3) return;
        t.kind      = k;
        t.err_code  = e;
        t.tok_start = start;
        t.tok_len   = (len > 25'(SAT24)) ? SAT24 : len[23:0];
        t.line_no   = sc_line;
        t.last      = 1'b0;
        step_toks.push_back(t);
    endtask

    task automatic reset_scan();
        sc_mode   = SC_IDLE;
        sc_begin  = '0;
        sc_pos    = '0;
        sc_line   = 24'd1;
        sc_window = '0;
        sc_wlen   = '0;
        sc_pend   = '0;
    endtask

    task automatic next_line();
        if (sc_line != SAT24) sc_line++;
    endtask

    // Scan a byte with no token open; report whether it ended the source.
    task automatic start_token(logic [7:0] c, output bit ended);
        ended   = 1'b0;
        sc_mode = SC_IDLE;
        if (c == CH_NUL) begin
            emit_token(K_EOF, E_NONE, sc_pos, 25'd0);
            ended = 1'b1;
        end else if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
        end else if (c == CH_LF) begin
            next_line();
        end else begin
            sc_begin = sc_pos;
            if (c == CH_SLASH) sc_mode = SC_SLASH;
            else if (letter_ch(c)) begin
                sc_mode   = SC_WORD;
                sc_window = 64'(c);
                sc_wlen   = 4'd1;
            end else if (digit_ch(c)) sc_mode = SC_INT;
            else if (c == CH_QUOTE) sc_mode = SC_STR;
            else if (c == CH_BANG || c == CH_EQ || c == CH_LT || c == CH_GT ||
                     c == CH_AMP || c == CH_BAR) begin
                sc_mode = SC_OP;
                sc_pend = c;
            end else if (punct_kind(c) != K_ERROR)
                emit_token(punct_kind(c), E_NONE, sc_pos, 25'd1);
            else emit_token(K_ERROR, E_UNEXP, sc_pos, 25'd1);
        end
    endtask

    // Advance the predictor by one byte and queue the tokens it sends.
    task automatic scan_byte(logic [7:0] c);
        bit          again;
        bit          ended;
        logic [24:0] span;
        t_kind       one_k;
        t_kind       two_k;
        again = 1'b0;
        ended = 1'b0;
        span  = 25'(sc_pos) - 25'(sc_begin);
        step_toks.delete();
        case (sc_mode)
            SC_WORD: begin
                if (letter_ch(c) || digit_ch(c)) begin
                    sc_window = {sc_window[55:0], c};
                    if (sc_wlen != 4'd15) sc_wlen++;
                end else begin
                    emit_token(word_kind(sc_window, sc_wlen), E_NONE, sc_begin, span);
                    again = 1'b1;
                end
            end
            SC_INT: begin
                if (c == CH_DOT) sc_mode = SC_DOT;
                else if (!digit_ch(c)) begin
                    emit_token(K_NUMBER, E_NONE, sc_begin, span);
                    again = 1'b1;
                end
            end
            SC_DOT: begin
                if (digit_ch(c)) sc_mode = SC_FRAC;
                else begin
                    emit_token(K_NUMBER, E_NONE, sc_begin, span - 25'd1);
                    emit_token(K_ERROR, E_UNEXP, sc_pos - 24'd1, 25'd1);
                    again = 1'b1;
                end
            end
            SC_FRAC: begin
                if (!digit_ch(c)) begin
                    emit_token(K_NUMBER, E_NONE, sc_begin, span);
                    again = 1'b1;
                end
            end
            SC_STR: begin
                if (c == CH_QUOTE) begin
                    emit_token(K_STRING, E_NONE, sc_begin, span + 25'd1);
                    sc_mode = SC_IDLE;
                end else if (c == CH_NUL) begin
                    emit_token(K_ERROR, E_UNTERM, sc_begin, span);
                    again = 1'b1;
                end else if (c == CH_LF) next_line();
            end
            SC_SLASH: begin
                if (c == CH_SLASH) sc_mode = SC_CMNT;
                else begin
                    emit_token(K_DIVIDE, E_NONE, sc_begin, 25'd1);
                    again = 1'b1;
                end
            end
            SC_CMNT: begin
                if (c == CH_LF || c == CH_NUL) again = 1'b1;
            end
            SC_OP: begin
                if (sc_pend == CH_AMP || sc_pend == CH_BAR) begin
                    if (c == sc_pend) begin
                        emit_token(sc_pend == CH_AMP ? K_AND : K_OR, E_NONE, sc_begin, 25'd2);
                        sc_mode = SC_IDLE;
                    end else begin
                        emit_token(K_ERROR, sc_pend == CH_AMP ? E_AMP : E_BAR, sc_begin,
                                   25'd1);
                        again = 1'b1;
                    end
                end else begin
                    case (sc_pend)
                        CH_BANG: begin one_k = K_NOT; two_k = K_NE;  end
                        CH_EQ:   begin one_k = K_ASSIGN; two_k = K_EQ; end
                        CH_GT:   begin one_k = K_GT; two_k = K_GTE; end
                        CH_LT:   begin one_k = K_LT; two_k = K_LTE; end
                        default: begin one_k = K_ERROR; two_k = K_ERROR; end
                    endcase
                    if (one_k == K_ERROR) begin
                        emit_token(K_ERROR, E_UNEXP, sc_begin, 25'd1);
                        again = 1'b1;
                    end else if (c == CH_EQ) begin
                        emit_token(two_k, E_NONE, sc_begin, 25'd2);
                        sc_mode = SC_IDLE;
                    end else begin
                        emit_token(one_k, E_NONE, sc_begin, 25'd1);
                        again = 1'b1;
                    end
                end
            end
            default: again = 1'b1;
        endcase
        if (again) start_token(c, ended);
        if (ended) reset_scan();
        else if (sc_pos != SAT24) sc_pos++;
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) token_queue.push_back(step_toks[i]);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
    endtask

    task automatic add_fragment();
        string words[16];
        string w;
        string ops;
        string blanks;
        int    n;
        words = '{"let", "if", "else", "print", "while", "for", "fn", "function",
                  "return", "true", "false", "int", "float", "bool", "string", "void"};
        ops    = "=<>!&|+-*;,:@(){}";
        blanks = " \t\r\n";
        case ($urandom_range(0, 11))
            0, 1: add_text(words[$urandom_range(0, 15)]);
            2: begin
                n = $urandom_range(1, 18);
                w = "";
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0: w = {w, string'(8'($urandom_range("0", "9")))};
                        1: w = {w, "_"};
                        2: w = {w, string'(8'($urandom_range("A", "Z")))};
                        default: w = {w, string'(8'($urandom_range("a", "z")))};
                    endcase
                    if (i == 0 && digit_ch(w[0])) w = "x";
                end
                add_text(w);
            end
            3: begin
                n = $urandom_range(1, 5);
                repeat (n) byte_queue.push_back(8'($urandom_range("0", "9")));
                if ($urandom_range(0, 1)) begin
                    byte_queue.push_back(CH_DOT);
                    if ($urandom_range(0, 3) != 0)
                        repeat ($urandom_range(1, 3))
                            byte_queue.push_back(8'($urandom_range("0", "9")));
                end
            end
            4: begin
                byte_queue.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 8)) byte_queue.push_back(8'($urandom_range(1, 255)));
                byte_queue.push_back(CH_QUOTE);
            end
            5: begin
                add_text("//");
                repeat ($urandom_range(0, 6)) byte_queue.push_back(8'($urandom_range(1, 255)));
                byte_queue.push_back(CH_LF);
            end
            6: begin
                case ($urandom_range(0, 9))
                    0: add_text("==");
                    1: add_text("!=");
                    2: add_text("<=");
                    3: add_text(">=");
                    4: add_text("&&");
                    5: add_text("||");
                    6: add_text("/");
                    default: byte_queue.push_back(ops[$urandom_range(0, 16)]);
                endcase
            end
            7, 8: byte_queue.push_back(blanks[$urandom_range(0, 3)]);
            9: byte_queue.push_back(8'($urandom_range(1, 255)));
            10: if ($urandom_range(0, 5) == 0) byte_queue.push_back(CH_NUL);
            default: byte_queue.push_back(CH_SPACE);
        endcase
    endtask

    // Stimulus
    initial begin
        add_text("let if else print while for fn function return true false\n");
        byte_queue.push_back(CH_NUL);
        add_text("int float bool string void xyz _A9 12 3.25 7.a \"hi\nx\" // c\n");
        byte_queue.push_back(CH_NUL);
        add_text("+-*/;,:@(){}= == ! != < <= > >= && || &x |y #");
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h80);
        add_text("functions \"open");
        byte_queue.push_back(CH_NUL);
        add_text("9.");
        byte_queue.push_back(CH_NUL);
        add_text("ab&");
        byte_queue.push_back(CH_NUL);
        while (byte_queue.size() < 350) add_fragment();
        byte_queue.push_back(CH_NUL);
        stim_done = 1'b1;
    end

    // Source driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            src.valid <= 1'b0;
            src.ch    <= '0;
        end else if (!src.valid || src_taken) begin
            if (src_gap > 0) begin
                src_gap   <= src_gap - 1;
                src.valid <= 1'b0;
            end else if (byte_queue.size() > 60 && $urandom_range(0, 6) == 0) begin
                src_gap   <= $urandom_range(0, 3);
                src.valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
                src.ch    <= byte_queue.pop_front();
                src.valid <= 1'b1;
            end else begin
                src.valid <= 1'b0;
            end
        end
    end

    // Token receiver ready, with one long hold-off to back up the input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tok.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            tok.ready <= 1'b0;
        end else if (!hold_used && accepted_bytes >= 120) begin
            hold_used <= 1'b1;
            hold_cnt  <= 60;
            tok.ready <= 1'b0;
        end else if (tok_gap > 0) begin
            tok_gap   <= tok_gap - 1;
            tok.ready <= 1'b0;
        end else if (byte_queue.size() > 60 && $urandom_range(0, 6) == 0) begin
            tok_gap   <= $urandom_range(0, 3);
            tok.ready <= 1'b0;
        end else begin
            tok.ready <= 1'b1;
        end
    end

    // Monitor: check tokens, then feed accepted bytes to the predictor
    always @(posedge i_clk) begin
        t_tok got;
        t_tok want;
        src_taken = 1'b0;
        if (i_rst_n) begin
            if (tok.valid && tok.ready) begin
                got.kind      = t_kind'(tok.kind);
                got.err_code  = t_err'(tok.err_code);
                got.tok_start = tok.tok_start;
                got.tok_len   = tok.tok_len;
                got.line_no   = tok.line_no;
                got.last      = tok.last;
                if (token_queue.size() == 0) begin
                    failed = 1'b1;
                    $display("%0t unexpected token: kind %0d start %0d len %0d", $time,
                             got.kind, got.tok_start, got.tok_len);
                end else begin
                    want = token_queue.pop_front();
                    if (got !== want) begin
                        failed = 1'b1;
                        $display({"%0t token mismatch: expected kind %0d err %0d start %0d",
                                  " len %0d line %0d last %0d, actual kind %0d err %0d",
                                  " start %0d len %0d line %0d last %0d"},
                                 $time, want.kind, want.err_code, want.tok_start, want.tok_len,
                                 want.line_no, want.last, got.kind, got.err_code, got.tok_start,
                                 got.tok_len, got.line_no, got.last);
                    end
                end
            end
            if (src.valid && src.ready) begin
                src_taken = 1'b1;
                accepted_bytes++;
                scan_byte(src.ch);
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("[source_token_scanner_core] ERROR");
            $finish;
        end
    end

    initial begin
        failed    = 1'b0;
        src_taken = 1'b0;
        hold_used = 1'b0;
        hold_cnt  = 0;
        src_gap   = 0;
        tok_gap   = 0;
        cycle_cnt = 0;
        accepted_bytes = 0;
        src.valid = 1'b0;
        src.ch    = '0;
        tok.ready = 1'b0;
        reset_scan();
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stim_done && byte_queue.size() == 0);
        @(posedge i_clk);
        while (src.valid || token_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed && token_queue.size() == 0) begin
            $display("[source_token_scanner_core] OK");
        end else begin
            $display("[source_token_scanner_core] ERROR");
        end
        $finish;
    end

endmodule
